// ===== rtl/urtc_pkg.sv =====
// Shared types, constants and codes of the serial receive ring buffer.
package urtc_pkg;

  // Default depth of the byte store.
  localparam int unsigned BUFFER_DEPTH = 64;

  // Fixed field widths.
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned AVAIL_W   = 6;
  localparam int unsigned MSG_CNT_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Request codes on the command port.
  localparam logic [REQ_W-1:0] REQ_RX_BYTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RD_BYTE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RD_MSG   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_USE_TERM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TERM_CHAR = 2'd1;

  // Saturation limit of the pending-message count.
  localparam logic [MSG_CNT_W-1:0] MSG_CNT_MAX = '1;

  // Classified operation carried through the queue.
  typedef enum logic [1:0] {
    OP_RECV,
    OP_RD_BYTE,
    OP_RD_MSG,
    OP_STATUS
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic              use_term;
    logic [BYTE_W-1:0] term_char;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    data_byte;
    logic                 data_valid;
    logic                 last;
    logic [AVAIL_W-1:0]   bytes_available;
    logic [MSG_CNT_W-1:0] messages_pending;
  } result_t;

endpackage

// ===== rtl/urtc_front.sv =====
// Front end: classifies requests and queues them for the back end.
module urtc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [urtc_pkg::REQ_W-1:0]    req_type_i,
  input  logic [urtc_pkg::BYTE_W-1:0]   rx_byte_i,
  output logic                          busy_o,
  output urtc_pkg::q_head_t             head_o,
  input  logic                          pop_i
);

  localparam int unsigned PtrW = (urtc_pkg::QUEUE_DEPTH > 1) ? $clog2(urtc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(urtc_pkg::QUEUE_DEPTH + 1);

  urtc_pkg::cmd_t queue_q [urtc_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  urtc_pkg::cmd_t  cmd_in;
  logic            push;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(urtc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    cmd_in.data = rx_byte_i;
    case (req_type_i)
      urtc_pkg::REQ_RX_BYTE: cmd_in.op = urtc_pkg::OP_RECV;
      urtc_pkg::REQ_RD_BYTE: cmd_in.op = urtc_pkg::OP_RD_BYTE;
      urtc_pkg::REQ_RD_MSG:  cmd_in.op = urtc_pkg::OP_RD_MSG;
      default:               cmd_in.op = urtc_pkg::OP_STATUS;
    endcase
  end

  assign busy_o       = (cnt_q == CntW'(urtc_pkg::QUEUE_DEPTH));
  assign push         = start_i && !busy_o;
  assign pop          = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/urtc_back.sv =====
// Back end: ring buffer store, indexes, message count and result generation.
module urtc_back #(
  parameter int unsigned BUFFER_DEPTH = urtc_pkg::BUFFER_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  urtc_pkg::q_head_t  head_i,
  output logic               pop_o,
  input  urtc_pkg::cfg_t     cfg_i,
  output urtc_pkg::result_t  result_o,
  output logic               strobe_o
);

  localparam int unsigned IdxW = $clog2(BUFFER_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_TAKE
  } state_e;

  state_e                            state_q, state_d;
  logic [IdxW-1:0]                   wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]                   rd_idx_q, rd_idx_d;
  logic [urtc_pkg::MSG_CNT_W-1:0]    msg_cnt_q, msg_cnt_d;
  logic                              msg_mode_q, msg_mode_d;
  urtc_pkg::result_t                 result_q, result_d;
  logic                              strobe_q, strobe_d;
  logic [urtc_pkg::BYTE_W-1:0]       byte_store_q [BUFFER_DEPTH];
  logic [urtc_pkg::BYTE_W-1:0]       rdata_q;
  logic                              mem_we;
  logic [IdxW-1:0]                   rd_idx_inc;
  logic [IdxW-1:0]                   fill_now;
  logic [IdxW-1:0]                   fill_after_take;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    idx_inc = (i == IdxW'(BUFFER_DEPTH - 1)) ? '0 : i + IdxW'(1);
  endfunction

  // Distance from the read index to the write index, modulo the depth.
  function automatic logic [IdxW-1:0] fill_of(input logic [IdxW-1:0] w,
                                              input logic [IdxW-1:0] r);
    logic [IdxW:0] t;
    t = {1'b0, w} + (IdxW+1)'(BUFFER_DEPTH) - {1'b0, r};
    if (t >= (IdxW+1)'(BUFFER_DEPTH)) begin
      t = t - (IdxW+1)'(BUFFER_DEPTH);
    end
    fill_of = t[IdxW-1:0];
  endfunction

  assign rd_idx_inc      = idx_inc(rd_idx_q);
  assign fill_now        = fill_of(wr_idx_q, rd_idx_q);
  assign fill_after_take = fill_of(wr_idx_q, rd_idx_inc);

  always_comb begin
    state_d                   = state_q;
    wr_idx_d                  = wr_idx_q;
    rd_idx_d                  = rd_idx_q;
    msg_cnt_d                 = msg_cnt_q;
    msg_mode_d                = msg_mode_q;
    strobe_d                  = 1'b0;
    pop_o                     = 1'b0;
    mem_we                    = 1'b0;
    result_d.data_byte        = '0;
    result_d.data_valid       = 1'b0;
    result_d.last             = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.cmd.op)
            urtc_pkg::OP_RECV: begin
              mem_we   = 1'b1;
              wr_idx_d = idx_inc(wr_idx_q);
              strobe_d = 1'b1;
              if (cfg_i.use_term && (head_i.cmd.data == cfg_i.term_char) &&
                  (msg_cnt_q != urtc_pkg::MSG_CNT_MAX)) begin
                msg_cnt_d = msg_cnt_q + urtc_pkg::MSG_CNT_W'(1);
              end
            end
            urtc_pkg::OP_RD_BYTE: begin
              if (fill_now == '0) begin
                strobe_d = 1'b1;
              end else begin
                msg_mode_d = 1'b0;
                state_d    = ST_TAKE;
              end
            end
            urtc_pkg::OP_RD_MSG: begin
              if ((msg_cnt_q == '0) || (fill_now == '0)) begin
                strobe_d = 1'b1;
              end else begin
                msg_mode_d = 1'b1;
                state_d    = ST_TAKE;
              end
            end
            default: begin
              strobe_d = 1'b1;
            end
          endcase
        end
      end
      ST_TAKE: begin
        strobe_d            = 1'b1;
        rd_idx_d            = rd_idx_inc;
        result_d.data_byte  = rdata_q;
        result_d.data_valid = 1'b1;
        if (!msg_mode_q) begin
          state_d = ST_IDLE;
        end else if (rdata_q == cfg_i.term_char) begin
          msg_cnt_d = msg_cnt_q - urtc_pkg::MSG_CNT_W'(1);
          state_d   = ST_IDLE;
        end else if (fill_after_take == '0) begin
          state_d = ST_IDLE;
        end else begin
          result_d.last = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    result_d.bytes_available  = urtc_pkg::AVAIL_W'(fill_of(wr_idx_d, rd_idx_d));
    result_d.messages_pending = msg_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      msg_cnt_q  <= '0;
      msg_mode_q <= 1'b0;
      strobe_q   <= 1'b0;
      result_q   <= '0;
    end else begin
      state_q    <= state_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      msg_cnt_q  <= msg_cnt_d;
      msg_mode_q <= msg_mode_d;
      strobe_q   <= strobe_d;
      result_q   <= result_d;
    end
  end

  // The read address follows the next read index, so a message read sees
  // the following byte in the cycle after taking the current one.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      byte_store_q[wr_idx_q] <= head_i.cmd.data;
    end
    rdata_q <= byte_store_q[rd_idx_d];
  end

  assign result_o = result_q;
  assign strobe_o = strobe_q;

endmodule

// ===== rtl/uart_rx_ring_with_terminator_count.sv =====
// Top level of the serial receive ring buffer with a pending-message count.
// A received byte, a status request or a read that takes nothing gives its result from
// the back end's output register; a byte read that takes a byte first passes ST_TAKE;
// a message read gives one result per cycle, one per byte, with last on the final one.
// The back end takes one receive per cycle; while a read is in ST_TAKE it takes no new
// command, and a 2-entry command queue absorbs the difference.
// Reset clears indexes, message count, configuration and queue; the store is not cleared.
module uart_rx_ring_with_terminator_count #(
  parameter int unsigned BUFFER_DEPTH = urtc_pkg::BUFFER_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command channel.
  input  logic                              start,
  output logic                              busy,
  input  logic [urtc_pkg::REQ_W-1:0]        req_type_i,
  input  logic [urtc_pkg::BYTE_W-1:0]       rx_byte_i,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [urtc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [urtc_pkg::BYTE_W-1:0]       cfg_data_i,
  // Result channel; every result is a one-cycle transfer.
  output logic                              result_strobe_o,
  output logic [urtc_pkg::BYTE_W-1:0]       data_byte_o,
  output logic                              data_valid_o,
  output logic                              last_o,
  output logic [urtc_pkg::AVAIL_W-1:0]      bytes_available_o,
  output logic [urtc_pkg::MSG_CNT_W-1:0]    messages_pending_o
);

  urtc_pkg::cfg_t    cfg_q, cfg_d;
  urtc_pkg::q_head_t head;
  logic              pop;
  urtc_pkg::result_t result;

  // Configuration registers. Writes are always taken; software must write them only
  // while no request is in flight (not enforced here), as the back end reads them live.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        urtc_pkg::CFG_IDX_USE_TERM:  cfg_d.use_term  = cfg_data_i[0];
        urtc_pkg::CFG_IDX_TERM_CHAR: cfg_d.term_char = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each accepted request and holds it in the
  // queue; busy goes high only while that queue is full.
  urtc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .busy_o     (busy),
    .head_o     (head),
    .pop_i      (pop)
  );

  // The back end owns the store, both indexes and the message count, and
  // produces every result from its output register.
  urtc_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .cfg_i    (cfg_q),
    .result_o (result),
    .strobe_o (result_strobe_o)
  );

  assign data_byte_o        = result.data_byte;
  assign data_valid_o       = result.data_valid;
  assign last_o             = result.last;
  assign bytes_available_o  = result.bytes_available;
  assign messages_pending_o = result.messages_pending;

  // A result that is not the last of its request always carries a byte.
  assert_not_last_has_data : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_o) |-> data_valid_o
  ) else $error("non-final result without a byte");

  // A message read streams its bytes without gaps.
  assert_msg_stream_unbroken : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_o) |=> result_strobe_o
  ) else $error("gap inside a message read");

  // The message count moves by at most one between back-to-back results.
  assert_msg_count_step : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && $past(result_strobe_o)) |->
      ((messages_pending_o == $past(messages_pending_o)) ||
       (messages_pending_o == $past(messages_pending_o) + 8'd1) ||
       (messages_pending_o == $past(messages_pending_o) - 8'd1))
  ) else $error("message count jumped");

endmodule
